// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

	localparam int WIDTH  = 32;             // significant bits of operands
	localparam int FW     = 32;             // numerator field width
	localparam int DENW   = 31;             // result denominator field width
	localparam int DW     = 2 * WIDTH;      // double-width intermediates
	localparam int CNT_W  = $clog2(DW);     // step counter / shift count

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_EQ  = 4'd4,
		OP_GT  = 4'd5,
		OP_LT  = 4'd6,
		OP_GE  = 4'd7,
		OP_LE  = 4'd8,
		OP_NEG = 4'd9,
		OP_ABS = 4'd10
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZDEN = 2'd1,
		ST_DIV0 = 2'd2,
		ST_OVF  = 2'd3
	} status_t;

	// which product the shared multiplier forms
	typedef enum logic [1:0] {
		MS_L = 2'd0,
		MS_R = 2'd1,
		MS_D = 2'd2
	} msel_t;

	// what the output register is loaded with
	typedef enum logic [2:0] {
		K_ARITH = 3'd0,
		K_CMP   = 3'd1,
		K_ZDEN  = 3'd2,
		K_DIV0  = 3'd3,
		K_NONE  = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_MWAIT,
		S_COMB,
		S_GCD,
		S_DIVN,
		S_NEXT,
		S_DIVD,
		S_FIN
	} state_t;

	typedef struct packed {
		logic  load;
		logic  mul_go;
		msel_t mul_sel;
		logic  comb;
		logic  gcd_step;
		logic  div_init;
		logic  div_sel_d;
		logic  div_step;
		logic  keep_n;
		logic  out_load;
		kind_t out_kind;
	} rau_cmd_t;

	typedef struct packed {
		logic [3:0] op;
		logic       zden;
		logic       div0;
		logic       gcd_done;
	} rau_sts_t;

endpackage

`default_nettype wire

// ===== design/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand capture, shared multiplier, combine, binary gcd and a
// restoring divider, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_dp
	import rau_pkg::*;
(
	input  wire logic            clk,
	input  wire rau_cmd_t        cmd,
	output rau_sts_t             sts,
	input  wire logic [3:0]      req_type,
	input  wire logic [FW-1:0]   a_num,
	input  wire logic [FW-1:0]   a_den,
	input  wire logic [FW-1:0]   b_num,
	input  wire logic [FW-1:0]   b_den,
	output logic [FW-1:0]        res_num,
	output logic [DENW-1:0]      res_den,
	output logic                 cmp_true,
	output logic [1:0]           status
);

	localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);

	function automatic logic [WIDTH-1:0] mag_f(input logic [WIDTH-1:0] v);
		mag_f = v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
	endfunction

	// captured operands: magnitudes and sign of each value
	logic [3:0]       op_q;
	logic [WIDTH-1:0] a_nm_q, a_dm_q, b_nm_q, b_dm_q;
	logic             a_s_q, b_s_q;

	// multiplier stage and product slots
	logic [DW-1:0]        p_q;
	logic                 ps_q, pv_q;
	msel_t                psel_q;
	logic signed [DW-1:0] l_q, r_q, d_q;

	// gcd / divider
	logic [DW-1:0]    nm_q, dm_q, u_q, v_q, g_q, x_q, qn_q;
	logic [DW:0]      rm_q;
	logic [CNT_W-1:0] k_q;
	logic             sgn_q, cmp_q;

	logic [WIDTH-1:0] mx, my;
	logic             msg;
	logic [DW-1:0]    pval;

	logic signed [DW:0] n_c;
	logic               nneg_c, dneg_c, nzero_c, cmp_c;
	logic [DW:0]        nmag_c;
	logic [DW-1:0]      dmag_c;

	logic [DW:0] rt_c;
	logic        rge_c;

	logic                    ovf_c;
	logic signed [WIDTH-1:0] rn_c;

	// operand select for the shared multiplier
	always_comb begin
		mx  = a_nm_q;
		my  = b_dm_q;
		msg = a_s_q;
		unique case (cmd.mul_sel)
			MS_L: begin
				unique case (op_q) inside
					OP_MUL: begin my = b_nm_q; msg = a_s_q ^ b_s_q; end
					OP_NEG: begin my = WIDTH'(1); msg = ~a_s_q; end
					OP_ABS: begin my = WIDTH'(1); msg = 1'b0; end
					default: begin my = b_dm_q; msg = a_s_q; end
				endcase
			end
			MS_R: begin
				mx  = b_nm_q;
				my  = a_dm_q;
				msg = b_s_q;
			end
			MS_D: begin
				mx = a_dm_q;
				unique case (op_q) inside
					OP_DIV: begin my = b_nm_q; msg = b_s_q; end
					OP_NEG, OP_ABS: begin my = WIDTH'(1); msg = 1'b0; end
					default: begin my = b_dm_q; msg = 1'b0; end
				endcase
			end
			default: begin
				mx  = a_nm_q;
				my  = b_dm_q;
				msg = a_s_q;
			end
		endcase
	end

	assign pval = ps_q ? (DW'(0) - p_q) : p_q;

	// combine products; compare ops form l - r
	always_comb begin
		unique case (op_q) inside
			OP_ADD: n_c = (DW+1)'(l_q) + (DW+1)'(r_q);
			OP_SUB, OP_EQ, OP_GT, OP_LT, OP_GE, OP_LE:
				n_c = (DW+1)'(l_q) - (DW+1)'(r_q);
			default: n_c = (DW+1)'(l_q);
		endcase
		nneg_c  = n_c[DW];
		nzero_c = (n_c == '0);
		nmag_c  = nneg_c ? ((DW+1)'(0) - n_c) : n_c;
		dneg_c  = d_q[DW-1];
		dmag_c  = dneg_c ? (DW'(0) - d_q) : d_q;
		unique case (op_q) inside
			OP_EQ:   cmp_c = nzero_c;
			OP_GT:   cmp_c = !nneg_c && !nzero_c;
			OP_LT:   cmp_c = nneg_c;
			OP_GE:   cmp_c = !nneg_c;
			OP_LE:   cmp_c = nneg_c || nzero_c;
			default: cmp_c = 1'b0;
		endcase
	end

	// restoring divider step
	assign rt_c  = {rm_q[DW-1:0], x_q[DW-1]};
	assign rge_c = (rt_c >= {1'b0, g_q});

	// overflow and signed result from the two quotients
	always_comb begin
		ovf_c = (x_q > (LIM - DW'(1))) || (qn_q > (sgn_q ? LIM : (LIM - DW'(1))));
		rn_c  = sgn_q ? (WIDTH'(0) - qn_q[WIDTH-1:0]) : qn_q[WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req_type;
			a_nm_q <= mag_f(a_num[WIDTH-1:0]);
			a_dm_q <= mag_f(a_den[WIDTH-1:0]);
			b_nm_q <= mag_f(b_num[WIDTH-1:0]);
			b_dm_q <= mag_f(b_den[WIDTH-1:0]);
			a_s_q  <= a_num[WIDTH-1] ^ a_den[WIDTH-1];
			b_s_q  <= b_num[WIDTH-1] ^ b_den[WIDTH-1];
		end

		pv_q <= cmd.mul_go;
		if (cmd.mul_go) begin
			p_q    <= DW'(mx) * DW'(my);
			ps_q   <= msg;
			psel_q <= cmd.mul_sel;
		end
		if (pv_q) begin
			case (psel_q)
				MS_L:    l_q <= pval;
				MS_R:    r_q <= pval;
				default: d_q <= pval;
			endcase
		end

		if (cmd.comb) begin
			nm_q  <= nmag_c[DW-1:0];
			dm_q  <= dmag_c;
			u_q   <= nmag_c[DW-1:0];
			v_q   <= dmag_c;
			k_q   <= '0;
			sgn_q <= nneg_c ^ dneg_c;
			cmp_q <= cmp_c;
		end else if (cmd.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + CNT_W'(1);
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end

		if (cmd.keep_n)
			qn_q <= x_q;
		if (cmd.div_init) begin
			x_q  <= cmd.div_sel_d ? dm_q : nm_q;
			rm_q <= '0;
			g_q  <= v_q << k_q;
		end else if (cmd.div_step) begin
			x_q  <= {x_q[DW-2:0], rge_c};
			rm_q <= rge_c ? (rt_c - {1'b0, g_q}) : rt_c;
		end

		if (cmd.out_load) begin
			res_num  <= '0;
			res_den  <= DENW'(1);
			cmp_true <= 1'b0;
			status   <= ST_OK;
			unique case (cmd.out_kind)
				K_ARITH: begin
					if (ovf_c) begin
						status <= ST_OVF;
					end else begin
						res_num <= FW'(rn_c);
						res_den <= DENW'(x_q[WIDTH-2:0]);
					end
				end
				K_CMP:  cmp_true <= cmp_q;
				K_ZDEN: status <= ST_ZDEN;
				K_DIV0: status <= ST_DIV0;
				default: status <= ST_OK;
			endcase
		end
	end

	always_comb begin
		sts.op       = op_q;
		sts.zden     = (a_dm_q == '0) ||
			(!(op_q == OP_NEG || op_q == OP_ABS) && (b_dm_q == '0));
		sts.div0     = (b_nm_q == '0);
		sts.gcd_done = (u_q == '0);
	end

endmodule

`default_nettype wire

// ===== design/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Controller: sequences check, products, combine, gcd and both divisions,
// and owns the handshake of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl
	import rau_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire rau_sts_t sts,
	output rau_cmd_t      cmd
);

	state_t           state_q, state_d;
	kind_t            kind_q, kind_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             ov_q, ov_d;
	logic             is_cmp;

	assign is_cmp = (sts.op == OP_EQ) || (sts.op == OP_GT) || (sts.op == OP_LT) ||
		(sts.op == OP_GE) || (sts.op == OP_LE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= K_NONE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		cnt_d    = cnt_q;
		ov_d     = ov_q && !out_ready;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.mul_sel  = MS_L;
		cmd.out_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cnt_d = '0;
				if (sts.op > OP_ABS) begin
					kind_d  = K_NONE;
					state_d = S_FIN;
				end else if (sts.zden) begin
					kind_d  = K_ZDEN;
					state_d = S_FIN;
				end else if (sts.op == OP_DIV && sts.div0) begin
					kind_d  = K_DIV0;
					state_d = S_FIN;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = msel_t'(cnt_q[1:0]);
				cnt_d       = cnt_q + CNT_W'(1);
				if (cnt_q[1:0] == MS_D)
					state_d = S_MWAIT;
			end
			S_MWAIT: state_d = S_COMB;
			S_COMB: begin
				cmd.comb = 1'b1;
				if (is_cmp) begin
					kind_d  = K_CMP;
					state_d = S_FIN;
				end else begin
					kind_d  = K_ARITH;
					state_d = S_GCD;
				end
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_init = 1'b1;
					cnt_d        = '0;
					state_d      = S_DIVN;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIVN: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DW - 1))
					state_d = S_NEXT;
			end
			S_NEXT: begin
				cmd.keep_n    = 1'b1;
				cmd.div_init  = 1'b1;
				cmd.div_sel_d = 1'b1;
				cnt_d         = '0;
				state_d       = S_DIVD;
			end
			S_DIVD: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DW - 1))
					state_d = S_FIN;
			end
			S_FIN: begin
				if (!ov_q || out_ready) begin
					cmd.out_load = 1'b1;
					ov_d         = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = ov_q;

endmodule

`default_nettype wire

// ===== design/rational_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Rational add/sub/mul/div, neg, abs and compares with gcd reduction.
// ----------------------------------------------------------------------------
// One transaction at a time. An error transaction (zero denominator, division
// by zero, undefined opcode) goes from the check state straight to the result;
// a compare skips the gcd and the divisions. Arithmetic runs through the shared
// 32x32 multiplier (3 products), a bit-serial binary gcd over the 64-bit result
// (one step per cycle) and two 64-step restoring divisions by the gcd; the gcd
// loop sets the spread in run time. A finished result sits in the output
// register while the next transaction is accepted; the unit only stalls in its
// final state if that result has still not been taken.
// Results come back reduced, denominator positive, sign on the numerator;
// errors and overflow return 0/1 with the status code.
`default_nettype none

module rational_arithmetic_unit_core
	import rau_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [3:0]      req_type,
	input  wire logic [FW-1:0]   a_num,
	input  wire logic [FW-1:0]   a_den,
	input  wire logic [FW-1:0]   b_num,
	input  wire logic [FW-1:0]   b_den,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [FW-1:0]        res_num,
	output logic [DENW-1:0]      res_den,
	output logic                 cmp_true,
	output logic [1:0]           status
);

	rau_cmd_t cmd;
	rau_sts_t sts;

	// sequencer: handshakes and step counts
	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic and result register
	rau_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.sts      (sts),
		.req_type (req_type),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.res_num  (res_num),
		.res_den  (res_den),
		.cmp_true (cmp_true),
		.status   (status)
	);

	// unit is busy right after accepting a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after accept");

	// every error result is 0/1 with no compare flag
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (res_num == '0 && res_den == DENW'(1) && !cmp_true))
		else $error("error result not 0/1");

	// a true compare carries a neutral 0/1 value
	a_cmp_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cmp_true) |-> (res_num == '0 && res_den == DENW'(1)))
		else $error("compare result not 0/1");

	// reduced denominator is never zero
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (res_den != '0))
		else $error("zero result denominator");

endmodule

`default_nettype wire

// ===== tb/rational_arithmetic_unit_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_tb
// Drives rational operand pairs and opcodes through the unit and compares each
// result with an in-bench prediction (exact 64-bit arithmetic, gcd reduction).
// ----------------------------------------------------------------------------

module rational_arithmetic_unit_core_tb;
	import rau_pkg::*;

	typedef struct {
		logic [FW-1:0]   num;
		logic [DENW-1:0] den;
		logic            cmp;
		status_t         st;
	} rat_result_t;

	// scoreboard: predicts each accepted transaction, checks results in order
	class rat_scoreboard;
		rat_result_t expected_q[$];
		int          errors = 0;

		// positive denominator, gcd divided out; d must be nonzero
		function void reduce(inout longint n, inout longint d);
			longint unsigned x, y, t;
			if (d < 0) begin
				n = -n;
				d = -d;
			end
			x = (n < 0) ? -n : n;
			y = d;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			if (x > 1) begin
				n = n / longint'(x);
				d = d / longint'(x);
			end
		endfunction

		function void note(logic [3:0] op, logic [FW-1:0] an_i, logic [FW-1:0] ad_i,
				logic [FW-1:0] bn_i, logic [FW-1:0] bd_i);
			longint      an, ad, bn, bd, rn, rd, lhs, rhs, lim;
			logic        arith, unary;
			rat_result_t r;
			an = longint'($signed(an_i[WIDTH-1:0]));
			ad = longint'($signed(ad_i[WIDTH-1:0]));
			bn = longint'($signed(bn_i[WIDTH-1:0]));
			bd = longint'($signed(bd_i[WIDTH-1:0]));
			lim = longint'(1) <<< (WIDTH - 1);
			rn = 0;
			rd = 1;
			arith = 1'b0;
			unary = (op == OP_NEG) || (op == OP_ABS);
			r.cmp = 1'b0;
			r.st = ST_OK;
			if (op <= OP_ABS) begin
				if (ad == 0 || (!unary && bd == 0)) begin
					r.st = ST_ZDEN;
				end else begin
					reduce(an, ad);
					if (!unary)
						reduce(bn, bd);
					lhs = an * bd;
					rhs = bn * ad;
					case (op)
						OP_ADD: begin rn = lhs + rhs; rd = ad * bd; arith = 1'b1; end
						OP_SUB: begin rn = lhs - rhs; rd = ad * bd; arith = 1'b1; end
						OP_MUL: begin rn = an * bn; rd = ad * bd; arith = 1'b1; end
						OP_DIV: begin
							if (bn == 0) begin
								r.st = ST_DIV0;
							end else begin
								rn = lhs;
								rd = ad * bn;
								arith = 1'b1;
							end
						end
						OP_NEG: begin rn = -an; rd = ad; arith = 1'b1; end
						OP_ABS: begin rn = (an < 0) ? -an : an; rd = ad; arith = 1'b1; end
						OP_EQ: r.cmp = (lhs == rhs);
						OP_GT: r.cmp = (lhs > rhs);
						OP_LT: r.cmp = (lhs < rhs);
						OP_GE: r.cmp = (lhs >= rhs);
						default: r.cmp = (lhs <= rhs);
					endcase
					if (arith) begin
						reduce(rn, rd);
						if (rn < -lim || rn > lim - 1 || rd > lim - 1) begin
							r.st = ST_OVF;
							rn = 0;
							rd = 1;
						end
					end
				end
			end
			r.num = rn[FW-1:0];
			r.den = rd[DENW-1:0];
			expected_q.push_back(r);
		endfunction

		function void check(logic [FW-1:0] num, logic [DENW-1:0] den, logic cmp,
				logic [1:0] st);
			rat_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result num=%0d den=%0d cmp=%0b status=%0d",
					$time, $signed(num), den, cmp, st);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (num !== e.num) begin
				$display("%0t: res_num expected %0d actual %0d", $time,
					$signed(e.num), $signed(num));
				errors++;
			end
			if (den !== e.den) begin
				$display("%0t: res_den expected %0d actual %0d", $time, e.den, den);
				errors++;
			end
			if (cmp !== e.cmp) begin
				$display("%0t: cmp_true expected %0b actual %0b", $time, e.cmp, cmp);
				errors++;
			end
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;  // cycles with no transaction at all
	localparam int HOLD_CYCLES = 800;    // long receiver hold-off
	localparam int N_RANDOM    = 1600;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [3:0]      req_type;
	logic [FW-1:0]   a_num, a_den, b_num, b_den;
	logic            out_valid;
	logic            out_ready;
	logic [FW-1:0]   res_num;
	logic [DENW-1:0] res_den;
	logic            cmp_true;
	logic [1:0]      status;

	rat_scoreboard sb;
	logic          calm;       // no idling on either side while set
	logic          hold_req;   // asks the receiver for a long hold-off
	int            quiet_cnt;

	rational_arithmetic_unit_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_num(res_num), .res_den(res_den), .cmp_true(cmp_true), .status(status)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		int hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold = 0;
		end else if (hold > 0) begin
			hold--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
		end
	end

	// result monitor; values sampled at the edge are the pre-edge ones
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check(res_num, res_den, cmp_true, status);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cnt <= 0;
		end else if (quiet_cnt >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cnt <= quiet_cnt + 1;
		end
	end

	// offer one transaction and return at the edge that accepts it
	task automatic send(logic [3:0] op, logic [FW-1:0] an, logic [FW-1:0] ad,
			logic [FW-1:0] bn, logic [FW-1:0] bd);
		in_valid <= 1'b1;
		req_type <= op;
		a_num    <= an;
		a_den    <= ad;
		b_num    <= bn;
		b_den    <= bd;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note(op, an, ad, bn, bd);
	endtask

	// random gap after an accepted transaction
	task automatic maybe_idle();
		if (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	endtask

	// operand mix: mostly small values, some extremes, some full-range
	function automatic logic [FW-1:0] pick_val(bit nonzero);
		logic [FW-1:0] v;
		int            sel;
		sel = $urandom_range(99);
		if (sel < 50)
			v = $urandom_range(200) - 100;
		else if (sel < 65)
			v = $urandom_range(2000000) - 1000000;
		else if (sel < 80) begin
			case ($urandom_range(5))
				0: v = 32'h7fffffff;
				1: v = 32'h80000000;
				2: v = 32'hffffffff;
				3: v = 32'd1;
				4: v = 32'h80000001;
				default: v = 32'd0;
			endcase
		end else
			v = $urandom;
		if (nonzero && v == 0)
			v = 1;
		return v;
	endfunction

	localparam logic [FW-1:0] MAXP = 32'h7fffffff;
	localparam logic [FW-1:0] MINN = 32'h80000000;

	initial begin
		logic [3:0] op;
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		req_type  = OP_ADD;
		a_num     = '0;
		a_den     = 32'd1;
		b_num     = '0;
		b_den     = 32'd1;
		calm      = 1'b0;
		hold_req  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed cases
		send(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);                    maybe_idle();
		send(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);                    maybe_idle(); // zero result
		send(OP_MUL, -32'sd3, 32'd4, 32'd8, -32'sd9);                maybe_idle();
		send(OP_DIV, 32'd2, 32'd3, -32'sd4, 32'd5);                  maybe_idle();
		send(OP_DIV, 32'd2, 32'd3, 32'd0, 32'd5);                    maybe_idle(); // div by zero
		send(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);                    maybe_idle(); // a den zero
		send(OP_DIV, 32'd1, 32'd1, 32'd0, 32'd0);                    maybe_idle(); // zden wins
		send(OP_NEG, 32'd5, -32'sd10, 32'd7, 32'd0);                 maybe_idle(); // b unused
		send(OP_ABS, -32'sd6, 32'd4, 32'd0, 32'd0);                  maybe_idle();
		send(OP_NEG, MINN, 32'd1, 32'd0, 32'd1);                     maybe_idle(); // overflow
		send(OP_ABS, MINN, 32'd1, 32'd0, 32'd1);                     maybe_idle(); // overflow
		send(OP_NEG, MINN, MINN, 32'd0, 32'd1);                      maybe_idle();
		send(OP_ADD, MAXP, 32'd1, MAXP, 32'd1);                      maybe_idle(); // overflow
		send(OP_MUL, MINN, MAXP, MINN, MINN);                        maybe_idle();
		send(OP_DIV, 32'd1, MAXP, MAXP, 32'd1);                      maybe_idle(); // den overflow
		send(OP_EQ, 32'd1, 32'd2, -32'sd2, -32'sd4);                 maybe_idle();
		send(OP_GT, 32'd1, 32'd3, 32'd1, 32'd2);                     maybe_idle();
		send(OP_LT, MINN, 32'd1, MAXP, 32'd1);                       maybe_idle();
		send(OP_GE, 32'd2, 32'd4, 32'd1, 32'd2);                     maybe_idle();
		send(OP_LE, MAXP, MINN, MINN, MAXP);                         maybe_idle();
		send(OP_EQ, 32'd1, 32'd1, 32'd1, 32'd0);                     maybe_idle(); // zden on compare
		send(4'd11, 32'd1, 32'd0, 32'd1, 32'd0);                     maybe_idle(); // undefined op
		send(4'd15, MINN, MAXP, 32'hffffffff, 32'hffffffff);         maybe_idle();

		// random part
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 600 && i < 900);
			if (i == 300)
				hold_req <= 1'b1;
			else if (i == 301)
				hold_req <= 1'b0;
			if (i == 1000) begin
				// drain completely before going on
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (sb.expected_q.size() != 0);
			end
			case ($urandom_range(99))
				0, 1, 2: op = $urandom_range(15, 11);
				default: op = $urandom_range(OP_ABS);
			endcase
			send(op, pick_val(0), ($urandom_range(49) == 0) ? '0 : pick_val(1),
				pick_val(0), ($urandom_range(49) == 0) ? '0 : pick_val(1));
			maybe_idle();
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== rational_arithmetic_unit_core.f =====
design/rau_pkg.sv
design/rau_dp.sv
design/rau_ctrl.sv
design/rational_arithmetic_unit_core.sv
tb/rational_arithmetic_unit_core_tb.sv
